// ----- hdl/mm2h_pkg.sv -----
// Package for the MurmurHash2 32-bit streaming hash block.
// Holds the mixing constants, the datapath opcodes and the command struct.
// No dependencies.
package mm2h_pkg;

  localparam logic [31:0] MUR_M = 32'h5bd1e995;
  localparam int unsigned SHIFT_K = 24;
  localparam int unsigned SHIFT_A1 = 13;
  localparam int unsigned SHIFT_A2 = 15;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_K1,
    OP_K2,
    OP_HMIX,
    OP_TAIL,
    OP_AVAL
  } mm2h_op_e;

  typedef struct packed {
    mm2h_op_e op;
    logic     load_len;
    logic     mask_tail;
  } mm2h_cmd_t;

endpackage

// ----- hdl/murmur2_hash_32.sv -----
// Streaming 32-bit MurmurHash2 (seed zero), one little-endian word per beat.
// Each input beat is taken in an accept step of its own, then the steps run on a
// single shared 32x32 multiplier, one multiply per cycle: a non-last beat or
// a full last word runs accept, two k multiplies and the h multiply, a last
// beat with 1 to 3 bytes runs accept and the tail multiply, a last beat with
// no bytes only accept; a last beat adds an avalanche step, which waits while
// a previous hash still sits unread in the output register. Beats that arrive
// with no message open and no first flag are dropped in their accept cycle.
// Depends on mm2h_pkg, mm2h_ctrl, mm2h_dp.
module murmur2_hash_32 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  valid_bytes_i,
  input  logic        first_item_i,
  input  logic        last_item_i,
  input  logic [31:0] message_length_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] hash_value_o
);
  import mm2h_pkg::*;

  mm2h_cmd_t cmd;

  mm2h_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .valid_bytes_i (valid_bytes_i),
    .first_item_i  (first_item_i),
    .last_item_i   (last_item_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .cmd_o         (cmd)
  );

  mm2h_dp u_dp (
    .clk_i            (clk_i),
    .cmd_i            (cmd),
    .data_word_i      (data_word_i),
    .valid_bytes_i    (valid_bytes_i),
    .message_length_i (message_length_i),
    .hash_value_o     (hash_value_o)
  );

endmodule

// ----- hdl/mm2h_dp.sv -----
// Datapath of the MurmurHash2 block: word, k and hash registers around one
// shared 32x32 multiplier by the constant M. Depends on mm2h_pkg.
module mm2h_dp (
  input  logic              clk_i,
  input  mm2h_pkg::mm2h_cmd_t cmd_i,
  input  logic [31:0]       data_word_i,
  input  logic [2:0]        valid_bytes_i,
  input  logic [31:0]       message_length_i,
  output logic [31:0]       hash_value_o
);
  import mm2h_pkg::*;

  logic [31:0] w_q, k_q, h_q, hash_q;
  logic [31:0] mask, mul_a, prod, aval;

  always_comb begin
    unique case (valid_bytes_i[1:0])
      2'd1:    mask = 32'h0000_00ff;
      2'd2:    mask = 32'h0000_ffff;
      2'd3:    mask = 32'h00ff_ffff;
      default: mask = 32'hffff_ffff;
    endcase
  end

  always_comb begin
    unique case (cmd_i.op)
      OP_K2:   mul_a = k_q ^ (k_q >> SHIFT_K);
      OP_HMIX: mul_a = h_q;
      OP_TAIL: mul_a = h_q ^ w_q;
      OP_AVAL: mul_a = h_q ^ (h_q >> SHIFT_A1);
      default: mul_a = w_q;
    endcase
  end

  assign prod = mul_a * MUR_M;
  assign aval = prod ^ (prod >> SHIFT_A2);

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        if (cmd_i.load_len) begin
          h_q <= message_length_i;
        end
        w_q <= cmd_i.mask_tail ? (data_word_i & mask) : data_word_i;
      end
      OP_K1, OP_K2: begin
        k_q <= prod;
      end
      OP_HMIX: begin
        h_q <= prod ^ k_q;
      end
      OP_TAIL: begin
        h_q <= prod;
      end
      OP_AVAL: begin
        h_q    <= aval;
        hash_q <= aval;
      end
      default: begin
      end
    endcase
  end

  assign hash_value_o = hash_q;

endmodule

// ----- hdl/mm2h_ctrl.sv -----
// Controller of the MurmurHash2 block: input handshake, message tracking,
// step sequencing and the output valid flag. Depends on mm2h_pkg.
module mm2h_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        valid_bytes_i,
  input  logic              first_item_i,
  input  logic              last_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mm2h_pkg::mm2h_cmd_t cmd_o
);
  import mm2h_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_K1   = 3'd1;
  localparam logic [2:0] ST_K2   = 3'd2;
  localparam logic [2:0] ST_HMIX = 3'd3;
  localparam logic [2:0] ST_TAIL = 3'd4;
  localparam logic [2:0] ST_AVAL = 3'd5;

  logic [2:0] state_q, state_d;
  logic       in_msg_q, in_msg_d;
  logic       last_q, last_d;
  logic       out_valid_q, out_valid_d;
  logic       accept, full_word, tail_word;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign full_word  = valid_bytes_i[2];
  assign tail_word  = !valid_bytes_i[2] && (valid_bytes_i[1:0] != 2'd0);

  always_comb begin
    state_d     = state_q;
    in_msg_d    = in_msg_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '{op: OP_NONE, load_len: 1'b0, mask_tail: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (first_item_i || in_msg_q)) begin
          cmd_o.op        = OP_LOAD;
          cmd_o.load_len  = first_item_i;
          cmd_o.mask_tail = last_item_i && tail_word;
          last_d          = last_item_i;
          in_msg_d        = !last_item_i;
          priority if (!last_item_i || full_word) begin
            state_d = ST_K1;
          end else if (tail_word) begin
            state_d = ST_TAIL;
          end else begin
            state_d = ST_AVAL;
          end
        end
      end
      ST_K1: begin
        cmd_o.op = OP_K1;
        state_d  = ST_K2;
      end
      ST_K2: begin
        cmd_o.op = OP_K2;
        state_d  = ST_HMIX;
      end
      ST_HMIX: begin
        cmd_o.op = OP_HMIX;
        state_d  = last_q ? ST_AVAL : ST_IDLE;
      end
      ST_TAIL: begin
        cmd_o.op = OP_TAIL;
        state_d  = ST_AVAL;
      end
      ST_AVAL: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = OP_AVAL;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_msg_q    <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_msg_q    <= in_msg_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- hdl/mm2h_checker.sv -----
// Port-level checks for murmur2_hash_32, bound to the top level below.
// No package dependencies.
module mm2h_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [2:0]  valid_bytes_i,
  input logic        first_item_i,
  input logic        last_item_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] hash_value_o
);

  logic in_beat;
  assign in_beat = in_valid_i && in_ready_o;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hash_value_o))
    else $error("stalled hash changed or dropped");

  a_first_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && first_item_i |=> !in_ready_o)
    else $error("ready after a first beat");

  a_out_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("hash appeared without a busy cycle");

  a_empty_msg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && first_item_i && last_item_i && (valid_bytes_i == 3'd0) && !out_valid_o
      |=> ##1 out_valid_o)
    else $error("empty message hash late");

endmodule

bind murmur2_hash_32 mm2h_checker u_mm2h_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .valid_bytes_i (valid_bytes_i),
  .first_item_i  (first_item_i),
  .last_item_i   (last_item_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .hash_value_o  (hash_value_o)
);
